[hdl/stec_pkg.sv]
// Shared types for the segment / triangle edge-crossing block.
// Holds the sign and equality flag bundle passed to the decision logic.
// No dependencies.
package stec_pkg;

    typedef logic [1:0] crossed_t;

    localparam crossed_t EDGE_NONE = 2'd0;

    // Per barycentric index: numerator equals D, is negative, is zero.
    typedef struct packed {
        logic       d_pos;
        logic [2:0] a_eq_d;
        logic [2:0] b_eq_d;
        logic [2:0] a_neg;
        logic [2:0] a_zero;
        logic [2:0] b_neg;
        logic [2:0] b_zero;
    } bary_flags_t;

endpackage

[hdl/stec_decide.sv]
// Edge-crossing decision from barycentric sign and equality flags.
// Depends on stec_pkg for the flag bundle and result type.
module stec_decide
    import stec_pkg::*;
(
    input  bary_flags_t flags,
    output crossed_t    crossed_edge
);

    always_comb begin
        crossed_t   res;
        crossed_t   last;
        logic       found;
        logic [1:0] cnt;
        logic       hit;
        res   = EDGE_NONE;
        last  = EDGE_NONE;
        found = 1'b0;
        cnt   = 2'd0;
        hit   = 1'b0;
        // endpoint sitting on a vertex takes priority, lowest index first
        for (int i = 0; i < 3; i++) begin
            if (!found && flags.a_eq_d[i]) begin
                found = 1'b1;
                res   = flags.b_neg[i] ? crossed_t'(i + 1) : EDGE_NONE;
            end else if (!found && flags.b_eq_d[i]) begin
                found = 1'b1;
                res   = flags.a_neg[i] ? crossed_t'(i + 1) : EDGE_NONE;
            end
        end
        // otherwise count coordinates whose signs differ or touch zero
        for (int i = 0; i < 3; i++) begin
            hit = (!flags.a_neg[i] && (flags.b_neg[i] || flags.b_zero[i])) ||
                  ((flags.a_neg[i] || flags.a_zero[i]) && !flags.b_neg[i]);
            if (hit) begin
                last = crossed_t'(i + 1);
                cnt  = cnt + 2'd1;
            end
        end
        if (!found) begin
            res = (cnt > 2'd1) ? last : EDGE_NONE;
        end
        if (!flags.d_pos) begin
            res = EDGE_NONE;
        end
        crossed_edge = res;
    end

endmodule

[hdl/segment_triangle_edge_crossing.sv]
// Segment / triangle edge-crossing predicate, exact integer arithmetic.
// Pipeline registers, in order: input, difference, product, cross, barycentric,
// result. Throughput: one transfer per cycle, set by the fully pipelined
// multiplier stage; the whole pipe stalls together when the result register is
// held. Reset clears only the stage valid bits.
// Depends on stec_pkg and stec_decide.
module segment_triangle_edge_crossing
    import stec_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, seg_a_x, seg_a_y, seg_b_x, seg_b_y
    input  logic [((10*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // crossed_edge [1:0], zero padded
    output logic [7:0]             m_tdata
);

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;        // coordinate difference
    localparam int PW = 2 * C + 2;    // product
    localparam int XW = 2 * C + 3;    // cross product
    localparam int NW = 2 * C + 4;    // barycentric numerator

    logic en;
    logic [4:0] vld_reg;
    logic       out_vld_reg;

    logic signed [C-1:0]  crd_reg [10];
    logic signed [DW-1:0] e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic signed [DW-1:0] dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [PW-1:0] pd0_reg, pd1_reg;
    logic signed [PW-1:0] pa0_reg, pa1_reg, pa2_reg, pa3_reg;
    logic signed [PW-1:0] pb0_reg, pb1_reg, pb2_reg, pb3_reg;
    logic signed [XW-1:0] d_reg, n1a_reg, n2a_reg, n1b_reg, n2b_reg;
    logic signed [NW-1:0] dn_reg, n0a_reg, n1an_reg, n2an_reg;
    logic signed [NW-1:0] n0b_reg, n1bn_reg, n2bn_reg;
    bary_flags_t          flags;
    crossed_t             edge_next;
    crossed_t             edge_reg;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[3:0], s_tvalid};
            out_vld_reg <= vld_reg[4];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 10; i++) begin
                crd_reg[i] <= s_tdata[i*C +: C];
            end
            // edges and endpoint offsets from v0
            e1x_reg <= DW'(crd_reg[2]) - DW'(crd_reg[0]);
            e1y_reg <= DW'(crd_reg[3]) - DW'(crd_reg[1]);
            e2x_reg <= DW'(crd_reg[4]) - DW'(crd_reg[0]);
            e2y_reg <= DW'(crd_reg[5]) - DW'(crd_reg[1]);
            dax_reg <= DW'(crd_reg[6]) - DW'(crd_reg[0]);
            day_reg <= DW'(crd_reg[7]) - DW'(crd_reg[1]);
            dbx_reg <= DW'(crd_reg[8]) - DW'(crd_reg[0]);
            dby_reg <= DW'(crd_reg[9]) - DW'(crd_reg[1]);
            // products
            pd0_reg <= PW'(e1x_reg) * PW'(e2y_reg);
            pd1_reg <= PW'(e1y_reg) * PW'(e2x_reg);
            pa0_reg <= PW'(dax_reg) * PW'(e2y_reg);
            pa1_reg <= PW'(day_reg) * PW'(e2x_reg);
            pa2_reg <= PW'(e1x_reg) * PW'(day_reg);
            pa3_reg <= PW'(e1y_reg) * PW'(dax_reg);
            pb0_reg <= PW'(dbx_reg) * PW'(e2y_reg);
            pb1_reg <= PW'(dby_reg) * PW'(e2x_reg);
            pb2_reg <= PW'(e1x_reg) * PW'(dby_reg);
            pb3_reg <= PW'(e1y_reg) * PW'(dbx_reg);
            // cross products
            d_reg   <= XW'(pd0_reg) - XW'(pd1_reg);
            n1a_reg <= XW'(pa0_reg) - XW'(pa1_reg);
            n2a_reg <= XW'(pa2_reg) - XW'(pa3_reg);
            n1b_reg <= XW'(pb0_reg) - XW'(pb1_reg);
            n2b_reg <= XW'(pb2_reg) - XW'(pb3_reg);
            // N0 = D - N1 - N2
            dn_reg   <= NW'(d_reg);
            n0a_reg  <= NW'(d_reg) - NW'(n1a_reg) - NW'(n2a_reg);
            n1an_reg <= NW'(n1a_reg);
            n2an_reg <= NW'(n2a_reg);
            n0b_reg  <= NW'(d_reg) - NW'(n1b_reg) - NW'(n2b_reg);
            n1bn_reg <= NW'(n1b_reg);
            n2bn_reg <= NW'(n2b_reg);
            edge_reg <= edge_next;
        end
    end

    always_comb begin
        flags.d_pos     = !dn_reg[NW-1] && (dn_reg != '0);
        flags.a_eq_d[0] = (n0a_reg == dn_reg);
        flags.a_eq_d[1] = (n1an_reg == dn_reg);
        flags.a_eq_d[2] = (n2an_reg == dn_reg);
        flags.b_eq_d[0] = (n0b_reg == dn_reg);
        flags.b_eq_d[1] = (n1bn_reg == dn_reg);
        flags.b_eq_d[2] = (n2bn_reg == dn_reg);
        flags.a_neg     = {n2an_reg[NW-1], n1an_reg[NW-1], n0a_reg[NW-1]};
        flags.b_neg     = {n2bn_reg[NW-1], n1bn_reg[NW-1], n0b_reg[NW-1]};
        flags.a_zero    = {n2an_reg == '0, n1an_reg == '0, n0a_reg == '0};
        flags.b_zero    = {n2bn_reg == '0, n1bn_reg == '0, n0b_reg == '0};
    end

    stec_decide u_decide (
        .flags        (flags),
        .crossed_edge (edge_next)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, edge_reg};

endmodule

[dv/stec_crossing_check.sv]
`timescale 1ns / 100ps
// Checker for the segment / triangle edge-crossing block: watches both stream
// channels, predicts crossed_edge per input transfer and compares in order.
// Depends on stec_pkg.
module stec_crossing_check
    import stec_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [((10*COORD_BITS+7)/8)*8-1:0]  s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [7:0]                          m_tdata,
    output int                                  mismatches,
    output int                                  outstanding
);

    localparam int DW = ((10*COORD_BITS+7)/8)*8;

    crossed_t expected_edges[$];
    int       error_count   = 0;
    int       pending_count = 0;

    assign mismatches  = error_count;
    assign outstanding = pending_count;

    // Exact form: D = e1 x e2, N1 = (P-v0) x e2, N2 = e1 x (P-v0), N0 = D-N1-N2.
    function automatic crossed_t predict_crossing(input logic [DW-1:0] pair);
        longint   p[10];
        longint   e1x, e1y, e2x, e2y, det, dx, dy;
        longint   n[2][3];
        int       hits;
        crossed_t last_hit;
        for (int k = 0; k < 10; k++) begin
            p[k] = longint'($signed(pair[k*COORD_BITS +: COORD_BITS]));
        end
        e1x = p[2] - p[0];
        e1y = p[3] - p[1];
        e2x = p[4] - p[0];
        e2y = p[5] - p[1];
        det = e1x * e2y - e1y * e2x;
        if (det <= 0)
            return EDGE_NONE;
        // endpoint 0 is A, endpoint 1 is B
        for (int e = 0; e < 2; e++) begin
            dx = p[6+2*e] - p[0];
            dy = p[7+2*e] - p[1];
            n[e][1] = dx * e2y - dy * e2x;
            n[e][2] = e1x * dy - e1y * dx;
            n[e][0] = det - n[e][1] - n[e][2];
        end
        // an endpoint with barycentric coordinate one decides on its own
        for (int i = 0; i < 3; i++) begin
            if (n[0][i] == det)
                return (n[1][i] < 0) ? crossed_t'(i + 1) : EDGE_NONE;
            if (n[1][i] == det)
                return (n[0][i] < 0) ? crossed_t'(i + 1) : EDGE_NONE;
        end
        hits = 0;
        last_hit = EDGE_NONE;
        for (int i = 0; i < 3; i++) begin
            if ((n[0][i] >= 0 && n[1][i] <= 0) || (n[0][i] <= 0 && n[1][i] >= 0)) begin
                hits++;
                last_hit = crossed_t'(i + 1);
            end
        end
        return (hits > 1) ? last_hit : EDGE_NONE;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %0s at %0t ns, got %0d, expected %0d", what, $time, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_tvalid && s_tready)
                expected_edges.push_back(predict_crossing(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_edges.size() == 0) begin
                    report_mismatch("result transfer with nothing expected",
                                    int'(m_tdata), 0);
                end else begin
                    if (m_tdata[1:0] !== expected_edges[0])
                        report_mismatch("crossed_edge", int'(m_tdata[1:0]),
                                        int'(expected_edges[0]));
                    if (m_tdata[7:2] !== 6'd0)
                        report_mismatch("tdata padding", int'(m_tdata[7:2]), 0);
                    void'(expected_edges.pop_front());
                end
            end
            pending_count <= expected_edges.size();
        end
    end

endmodule

[dv/segment_triangle_edge_crossing_tb.sv]
`timescale 1ns / 100ps
// Top of the edge-crossing testbench: clock, reset, stimulus and verdict.
// Depends on the block and stec_crossing_check.
module segment_triangle_edge_crossing_tb;

    localparam int CB         = 24;
    localparam int DW         = ((10*CB+7)/8)*8;
    localparam int CMIN       = -8388608;
    localparam int CMAX       = 8388607;
    localparam int N_RANDOM   = 650;
    localparam int QUIET_MAX  = 2000;
    localparam int HOLD_LEN   = 80;

    typedef enum int {SPREAD_NOISE, SPREAD_TINY, SPREAD_MID, SPREAD_FULL, SPREAD_CORNER}
        spread_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [DW-1:0] s_tdata;   // v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, a_x, a_y, b_x, b_y
    logic          m_tvalid;
    logic          m_tready;
    logic [7:0]    m_tdata;   // crossed_edge [1:0], zero padded

    int mismatches;
    int outstanding;
    int pairs_sent  = 0;
    int quiet_count = 0;
    bit hold_done   = 1'b0;

    segment_triangle_edge_crossing #(.COORD_BITS(CB)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    stec_crossing_check #(.COORD_BITS(CB)) crossing_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [DW-1:0] pack_pair(input int c[10]);
        logic [DW-1:0] w;
        w = '0;
        for (int k = 0; k < 10; k++) begin
            w[k*CB +: CB] = c[k][CB-1:0];
        end
        return w;
    endfunction

    function automatic int random_coord(input spread_t spread);
        logic [31:0] r;
        int          corners[5];
        corners = '{CMIN, CMAX, 0, -1, 1};
        r = $urandom;
        case (spread)
            SPREAD_TINY:   return $urandom_range(12) - 6;
            SPREAD_MID:    return $urandom_range(4000) - 2000;
            SPREAD_CORNER: return corners[$urandom_range(4)];
            default:       return int'($signed(r[CB-1:0]));
        endcase
    endfunction

    // Mostly counter-clockwise triangles, with endpoints often snapped onto a
    // vertex; small spreads make zero and equal numerators common.
    function automatic logic [DW-1:0] random_pair();
        int            c[10];
        int            t;
        int            pick;
        spread_t       spread;
        longint        orient;
        logic [DW-1:0] w;
        pick = $urandom_range(9);
        if (pick == 0) begin
            for (int k = 0; k < DW; k += 32) begin
                w[k +: 16] = 16'($urandom);
                if (k + 16 < DW)
                    w[k+16 +: 16] = 16'($urandom);
            end
            return w;
        end
        spread = (pick <= 3) ? SPREAD_TINY : (pick <= 5) ? SPREAD_MID :
                 (pick <= 8) ? SPREAD_FULL : SPREAD_CORNER;
        for (int k = 0; k < 10; k++) begin
            c[k] = random_coord(spread);
        end
        orient = (longint'(c[2]) - c[0]) * (longint'(c[5]) - c[1])
               - (longint'(c[3]) - c[1]) * (longint'(c[4]) - c[0]);
        if (orient < 0 && $urandom_range(9) != 0) begin
            t = c[2]; c[2] = c[4]; c[4] = t;
            t = c[3]; c[3] = c[5]; c[5] = t;
        end
        t = $urandom_range(9);
        pick = 2 * $urandom_range(2);
        if (t < 2) begin
            c[6] = c[pick];
            c[7] = c[pick+1];
        end else if (t < 4) begin
            c[8] = c[pick];
            c[9] = c[pick+1];
        end
        return pack_pair(c);
    endfunction

    task automatic send_pair(input logic [DW-1:0] pair);
        while (!(pairs_sent >= 100 && pairs_sent < 420) && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pair;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pairs_sent++;
    endtask

    task automatic send_coords(input int c[10]);
        send_pair(pack_pair(c));
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes and degenerate or clockwise triangles
        send_coords('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_coords('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
        send_coords('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN});
        send_coords('{0, 0, 0, 100, 100, 0, -10, 10, 50, 10});
        send_coords('{CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN});
        send_coords('{CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX});
        send_coords('{-5, -5, 5, -5, -5, 5, CMIN, CMIN, CMAX, CMAX});
        // endpoint on each vertex, other endpoint outside and inside
        send_coords('{0, 0, 100, 0, 0, 100, 0, 0, 100, 100});
        send_coords('{0, 0, 100, 0, 0, 100, 0, 0, 10, 10});
        send_coords('{0, 0, 100, 0, 0, 100, -50, 50, 100, 0});
        send_coords('{0, 0, 100, 0, 0, 100, 100, 0, 20, 20});
        send_coords('{0, 0, 100, 0, 0, 100, 0, 100, 50, -20});
        send_coords('{0, 0, 100, 0, 0, 100, 30, -5, 0, 100});
        send_coords('{0, 0, 100, 0, 0, 100, 0, 0, 100, 0});
        // on the line through v0 parallel to the far edge: N0 equals D off the vertex
        send_coords('{0, 0, 100, 0, 0, 100, -10, 10, 60, 60});
        // sign counting: crossing, inside, along an edge, through a vertex, point
        send_coords('{0, 0, 100, 0, 0, 100, -10, 50, 50, -10});
        send_coords('{0, 0, 100, 0, 0, 100, 10, 10, 20, 20});
        send_coords('{0, 0, 100, 0, 0, 100, 10, 0, 50, 0});
        send_coords('{0, 0, 100, 0, 0, 100, -10, -10, 10, 10});
        send_coords('{0, 0, 100, 0, 0, 100, 30, 30, 30, 30});
        send_coords('{0, 0, 100, 0, 0, 100, 200, -50, -50, 200});

        for (int n = 0; n < N_RANDOM; n++) begin
            send_pair(random_pair());
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("segment_triangle_edge_crossing_tb passed");
        else
            $display("segment_triangle_edge_crossing_tb failed");
        $finish;
    end

    // Result side: random stalls, one long hold-off while the sender keeps
    // offering, and a stretch with no stalls at all.
    initial begin
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (!hold_done && pairs_sent >= 120) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end else begin
                m_tready <= (pairs_sent >= 300 && pairs_sent < 420) ||
                            ($urandom_range(99) >= 14);
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_count <= 0;
            else
                quiet_count <= quiet_count + 1;
            if (quiet_count >= QUIET_MAX) begin
                $display("segment_triangle_edge_crossing_tb failed");
                $finish;
            end
        end
    end

endmodule
